// ----- hdl/ssag_pkg.sv -----
// ----------------------------------------------------------------------------
// ssag_pkg
// Types and codes shared by the strided slab address generator.
// ----------------------------------------------------------------------------
package ssag_pkg;

	// Request function codes.
	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_NEXT  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_CELL_BYTES    = 2'd0;
	localparam logic [1:0] CFG_SLAB_ELEMENTS = 2'd1;
	localparam logic [1:0] CFG_DIMS_IN_USE   = 2'd2;

	localparam int CFG_DATA_W = 32;
	localparam int BYTE_W     = 40;

	typedef struct packed {
		logic [1:0]  func;
		logic [1:0]  dim_index;
		logic [31:0] range_last;
		logic [31:0] dest_stride_el;
		logic [31:0] src_stride_el;
		logic [31:0] dest_start_el;
		logic [31:0] src_start_el;
	} req_t;

	typedef struct packed {
		logic [39:0] src_byte_offset;
		logic [39:0] dest_byte_offset;
		logic [39:0] byte_count;
		logic        last;
	} res_t;

endpackage

// ----- hdl/strided_slab_address_generator_unit.sv -----
// ----------------------------------------------------------------------------
// strided_slab_address_generator_unit
// Walks a nested strided copy and issues one slab address per next request.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A load or start
// request keeps the block busy through MUL_A and MUL_B, one multiply each;
// a load of a dimension at or beyond MAX_DIMS is dropped at once. A next
// request while the walker is idle is dropped and the block is ready again in
// the following cycle. A next request during a walk passes through MUL_A,
// then the carry scan, which visits 1 to n dimensions (n being dims_in_use
// clamped to the range 1 to MAX_DIMS), then ADD_D and ADD_S; the final slab
// of a walk scans all n dimensions and skips the adds. The steps are set by
// the single 32 x 9 multiplier, the single 40-bit adder and the carry scan,
// which checks one dimension per cycle. The slab is presented on result for
// exactly one cycle with result_valid high; there is no backpressure, so the
// receiver must take it in that cycle.
module strided_slab_address_generator_unit
	import ssag_pkg::*;
#(
	parameter int MAX_DIMS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  req_t                  req,
	output res_t                  result,
	output logic                  result_valid,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam logic [3:0] MAX_LAST = 4'(MAX_DIMS - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL_A = 3'd1;
	localparam logic [2:0] ST_MUL_B = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_ADD_D = 3'd4;
	localparam logic [2:0] ST_ADD_S = 3'd5;

	logic [2:0]        state_q;
	req_t              req_q;
	logic [8:0]        cell_bytes_q;
	logic [31:0]       slab_elements_q;
	logic [2:0]        dims_in_use_q;
	logic              active_q;
	logic [DW-1:0]     k_q;
	logic [BYTE_W-1:0] tmp_q;
	res_t              result_q;
	logic              result_valid_q;

	logic [31:0]       coord_q       [MAX_DIMS];
	logic [31:0]       coord_last_q  [MAX_DIMS];
	logic [BYTE_W-1:0] dest_stride_q [MAX_DIMS];
	logic [BYTE_W-1:0] src_stride_q  [MAX_DIMS];
	logic [BYTE_W-1:0] dest_offset_q [MAX_DIMS];
	logic [BYTE_W-1:0] src_offset_q  [MAX_DIMS];

	logic              accept;
	logic [3:0]        dims_ext;
	logic [3:0]        last_wide;
	logic [DW-1:0]     last_idx;
	logic [DW-1:0]     load_idx;
	logic              load_ok;
	logic [31:0]       mul_a;
	logic [40:0]       mul_p;
	logic [BYTE_W-1:0] prod;
	logic [BYTE_W-1:0] add_a;
	logic [BYTE_W-1:0] add_b;
	logic [BYTE_W-1:0] sum;
	logic              wrap;

	assign busy         = (state_q != ST_IDLE);
	assign accept       = start && !busy;
	assign result       = result_q;
	assign result_valid = result_valid_q;

	// Effective innermost dimension: zero counts as one, large values clamp.
	assign dims_ext  = {1'b0, dims_in_use_q};
	always_comb begin
		if (dims_in_use_q == 3'd0) begin
			last_wide = 4'd0;
		end else if (dims_ext > 4'(MAX_DIMS)) begin
			last_wide = MAX_LAST;
		end else begin
			last_wide = dims_ext - 4'd1;
		end
	end
	assign last_idx = last_wide[DW-1:0];

	assign load_idx = DW'(req_q.dim_index);
	assign load_ok  = (32'(req_q.dim_index) < 32'(MAX_DIMS));

	// Shared multiplier: cells to bytes.
	always_comb begin
		case (state_q)
			ST_MUL_A: begin
				case (req_q.func)
					FUNC_LOAD:  mul_a = req_q.dest_stride_el;
					FUNC_START: mul_a = req_q.dest_start_el;
					default:    mul_a = slab_elements_q;
				endcase
			end
			default: begin
				if (req_q.func == FUNC_LOAD) begin
					mul_a = req_q.src_stride_el;
				end else begin
					mul_a = req_q.src_start_el;
				end
			end
		endcase
	end
	assign mul_p = mul_a * cell_bytes_q;
	assign prod  = mul_p[BYTE_W-1:0];

	// Shared adder: coordinate increment and offset stepping.
	always_comb begin
		case (state_q)
			ST_ADD_D: begin
				add_a = dest_offset_q[k_q];
				add_b = dest_stride_q[k_q];
			end
			ST_ADD_S: begin
				add_a = src_offset_q[k_q];
				add_b = src_stride_q[k_q];
			end
			default: begin
				add_a = {8'd0, coord_q[k_q]};
				add_b = 40'd1;
			end
		endcase
	end
	assign sum  = add_a + add_b;
	assign wrap = (coord_q[k_q] >= coord_last_q[k_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			req_q           <= '0;
			cell_bytes_q    <= 9'd1;
			slab_elements_q <= 32'd1;
			dims_in_use_q   <= 3'd1;
			active_q        <= 1'b0;
			k_q             <= '0;
			tmp_q           <= '0;
			result_q        <= '0;
			result_valid_q  <= 1'b0;
			for (int i = 0; i < MAX_DIMS; i++) begin
				coord_q[i]       <= '0;
				coord_last_q[i]  <= '0;
				dest_stride_q[i] <= '0;
				src_stride_q[i]  <= '0;
				dest_offset_q[i] <= '0;
				src_offset_q[i]  <= '0;
			end
		end else begin
			// A slab leaves the scan when a dimension steps or the outermost one wraps.
			result_valid_q <= (state_q == ST_SCAN) && (!wrap || (k_q == '0));

			if (cfg_we) begin
				case (cfg_index)
					CFG_CELL_BYTES:    cell_bytes_q    <= cfg_data[8:0];
					CFG_SLAB_ELEMENTS: slab_elements_q <= cfg_data;
					CFG_DIMS_IN_USE:   dims_in_use_q   <= cfg_data[2:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_q <= req;
						case (req.func)
							FUNC_LOAD: begin
								if (32'(req.dim_index) < 32'(MAX_DIMS)) begin
									state_q <= ST_MUL_A;
								end
							end
							FUNC_START: state_q <= ST_MUL_A;
							FUNC_NEXT: begin
								if (active_q) begin
									state_q <= ST_MUL_A;
								end
							end
							default: ;
						endcase
					end
				end
				ST_MUL_A: begin
					case (req_q.func)
						FUNC_LOAD: begin
							if (load_ok) begin
								dest_stride_q[load_idx] <= prod;
							end
							state_q <= ST_MUL_B;
						end
						FUNC_START: begin
							tmp_q   <= prod;
							state_q <= ST_MUL_B;
						end
						default: begin
							// Byte count is held until the carry scan decides the last flag.
							tmp_q   <= prod;
							k_q     <= last_idx;
							state_q <= ST_SCAN;
						end
					endcase
				end
				ST_MUL_B: begin
					if (req_q.func == FUNC_LOAD) begin
						if (load_ok) begin
							src_stride_q[load_idx] <= prod;
							coord_last_q[load_idx] <= req_q.range_last;
						end
					end else begin
						for (int i = 0; i < MAX_DIMS; i++) begin
							dest_offset_q[i] <= tmp_q;
							src_offset_q[i]  <= prod;
							coord_q[i]       <= '0;
						end
						active_q <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					result_q.src_byte_offset  <= src_offset_q[last_idx];
					result_q.dest_byte_offset <= dest_offset_q[last_idx];
					result_q.byte_count       <= tmp_q;
					if (wrap) begin
						coord_q[k_q] <= '0;
						if (k_q == '0) begin
							result_q.last <= 1'b1;
							active_q      <= 1'b0;
							state_q       <= ST_IDLE;
						end else begin
							k_q <= k_q - 1'b1;
						end
					end else begin
						coord_q[k_q]  <= sum[31:0];
						result_q.last <= 1'b0;
						state_q       <= ST_ADD_D;
					end
				end
				ST_ADD_D: begin
					// The stepped dimension and every inner one take the new offset.
					for (int i = 0; i < MAX_DIMS; i++) begin
						if ((DW'(i) >= k_q) && (DW'(i) <= last_idx)) begin
							dest_offset_q[i] <= sum;
						end
					end
					state_q <= ST_ADD_S;
				end
				ST_ADD_S: begin
					for (int i = 0; i < MAX_DIMS; i++) begin
						if ((DW'(i) >= k_q) && (DW'(i) <= last_idx)) begin
							src_offset_q[i] <= sum;
						end
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_result_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result issued without a request in progress");

	a_result_single_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe lasted more than one cycle");

	a_last_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last) |-> !active_q)
		else $error("walker still armed after the final slab");

	a_scan_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (k_q <= last_idx))
		else $error("carry scan index beyond the innermost dimension");

endmodule

// ----- test/strided_slab_address_generator_unit_test.sv -----
// ----------------------------------------------------------------------------
// strided_slab_address_generator_unit_test
// Self-checking testbench for the strided slab address generator. A short
// stimulus table covers reset values, extreme strides and register values,
// and the odd cases of the walker. Random walks follow, with loads, restarts
// and ignored requests mixed in. A slab is checked against the one its table
// row gives, if any, else a predictor with its own odometer, offsets, registers.
// ----------------------------------------------------------------------------
module strided_slab_address_generator_unit_test;
	import ssag_pkg::*;

	localparam int DIMS        = 4;
	localparam int TARGET      = 1950;
	localparam int CALM_TAIL   = 250;
	localparam int SETTLE      = 12;
	localparam int STALL_LIMIT = 2000;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [1:0] CFG_UNUSED  = 2'd3;

	typedef struct {
		bit          is_reg;
		logic [1:0]  reg_idx;
		logic [31:0] reg_val;
		req_t        rq;
		bit          typed;
		res_t        want;
	} row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic                  busy;
	req_t                  req       = '0;
	res_t                  result;
	logic                  result_valid;
	logic                  cfg_we    = 1'b0;
	logic [1:0]            cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	strided_slab_address_generator_unit #(
		.MAX_DIMS(DIMS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.result      (result),
		.result_valid(result_valid),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow registers and walker state.
	logic [8:0]  sh_cell_bytes;
	logic [31:0] sh_slab_len;
	logic [2:0]  sh_dims;
	logic [31:0] odo_coord [DIMS];
	logic [31:0] odo_last  [DIMS];
	logic [39:0] dst_step  [DIMS];
	logic [39:0] src_step  [DIMS];
	logic [39:0] dst_base  [DIMS];
	logic [39:0] src_base  [DIMS];
	bit          walking;

	res_t slab_q[$];
	bit   typed_pending = 1'b0;
	res_t typed_want    = '0;
	bit   gappy         = 1'b0;
	int   errors        = 0;
	int   slabs_seen    = 0;
	int   walks_done    = 0;
	int   useful        = 0;
	int   settings_used = 0;
	int   stall_count   = 0;

	function automatic logic [39:0] cells_to_bytes(input logic [31:0] cells);
		logic [63:0] p;
		p = 64'(cells) * 64'(sh_cell_bytes);
		return p[39:0];
	endfunction

	// Applies one request to the shadow walker; got is set when a slab comes out.
	task automatic step_walker(input req_t r, output bit got, output res_t s);
		int n;
		int k;
		bit done;
		got = 1'b0;
		s = '0;
		case (r.func)
			FUNC_LOAD: begin
				odo_last[r.dim_index] = r.range_last;
				dst_step[r.dim_index] = cells_to_bytes(r.dest_stride_el);
				src_step[r.dim_index] = cells_to_bytes(r.src_stride_el);
			end
			FUNC_START: begin
				for (int i = 0; i < DIMS; i++) begin
					dst_base[i] = cells_to_bytes(r.dest_start_el);
					src_base[i] = cells_to_bytes(r.src_start_el);
					odo_coord[i] = '0;
				end
				walking = 1'b1;
			end
			FUNC_NEXT: if (walking) begin
				n = (sh_dims == 0) ? 1 : (sh_dims > DIMS) ? DIMS : int'(sh_dims);
				s.src_byte_offset = src_base[n-1];
				s.dest_byte_offset = dst_base[n-1];
				s.byte_count = cells_to_bytes(sh_slab_len);
				done = 1'b1;
				// A coordinate at or past its last value wraps and carries outward.
				for (k = n - 1; k >= 0; k--) begin
					if (odo_coord[k] >= odo_last[k]) begin
						odo_coord[k] = '0;
					end else begin
						odo_coord[k] = odo_coord[k] + 32'd1;
						done = 1'b0;
						break;
					end
				end
				if (done) begin
					walking = 1'b0;
				end else begin
					dst_base[k] = dst_base[k] + dst_step[k];
					src_base[k] = src_base[k] + src_step[k];
					for (int i = k + 1; i < n; i++) begin
						dst_base[i] = dst_base[k];
						src_base[i] = src_base[k];
					end
				end
				s.last = done;
				got = 1'b1;
			end
			default: ;
		endcase
	endtask

	// Register shadow, slab checking, prediction and the watchdog.
	always @(posedge clk) begin
		bit   got;
		res_t s;
		res_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CELL_BYTES:    sh_cell_bytes = cfg_data[8:0];
					CFG_SLAB_ELEMENTS: sh_slab_len = cfg_data;
					CFG_DIMS_IN_USE:   sh_dims = cfg_data[2:0];
					default: ;
				endcase
			end
			if (result_valid) begin
				if (slab_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected slab: src %h dest %h count %h last %b",
							result.src_byte_offset, result.dest_byte_offset,
							result.byte_count, result.last);
				end else begin
					want = slab_q.pop_front();
					slabs_seen++;
					if (result.last)
						walks_done++;
					if (result.src_byte_offset !== want.src_byte_offset ||
						result.dest_byte_offset !== want.dest_byte_offset ||
						result.byte_count !== want.byte_count ||
						result.last !== want.last) begin
						errors++;
						if (errors <= 10) begin
							$display("slab mismatch, expected src %h dest %h count %h last %b",
								want.src_byte_offset, want.dest_byte_offset,
								want.byte_count, want.last);
							$display("               actual   src %h dest %h count %h last %b",
								result.src_byte_offset, result.dest_byte_offset,
								result.byte_count, result.last);
						end
					end
				end
			end
			if (start && !busy) begin
				step_walker(req, got, s);
				if (typed_pending) begin
					got = 1'b1;
					s = typed_want;
				end
				if (got)
					slab_q.insert(slab_q.size(), s);
			end
			if ((start && !busy) || result_valid)
				stall_count = 0;
			else
				stall_count++;
			if (stall_count >= STALL_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Every driver task starts and ends at a falling edge.
	task automatic send(input req_t r);
		start = 1'b1;
		req = r;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic pause(input int n);
		start = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		start = 1'b0;
		while (slab_q.size() != 0 || busy) @(negedge clk);
	endtask

	// Loads, starts and ignored requests produce nothing, so allow for their
	// remaining cycles before touching a register.
	task automatic settle();
		drain();
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
	endtask

	task automatic feed(input req_t r);
		if (r.func == FUNC_LOAD || r.func == FUNC_START || (r.func == FUNC_NEXT && walking))
			useful++;
		if (gappy && useful < TARGET - CALM_TAIL && $urandom_range(0, 9) == 0)
			pause($urandom_range(1, 18));
		send(r);
	endtask

	function automatic req_t noise_req(input logic [1:0] f);
		req_t r;
		r.func = f;
		r.dim_index = 2'($urandom);
		r.range_last = $urandom;
		r.dest_stride_el = $urandom;
		r.src_stride_el = $urandom;
		r.dest_start_el = $urandom;
		r.src_start_el = $urandom;
		return r;
	endfunction

	function automatic req_t load_req(input logic [1:0] d, input logic [31:0] last,
		input logic [31:0] ds, input logic [31:0] ss);
		req_t r;
		r = noise_req(FUNC_LOAD);
		r.dim_index = d;
		r.range_last = last;
		r.dest_stride_el = ds;
		r.src_stride_el = ss;
		return r;
	endfunction

	function automatic req_t start_req(input logic [31:0] ds, input logic [31:0] ss);
		req_t r;
		r = noise_req(FUNC_START);
		r.dest_start_el = ds;
		r.src_start_el = ss;
		return r;
	endfunction

	function automatic logic [31:0] pick_last();
		int c;
		c = $urandom_range(0, 15);
		if (c < 10)
			return $urandom_range(0, 2);
		else if (c < 14)
			return $urandom_range(3, 7);
		else if (c == 14)
			return $urandom;
		return 32'hFFFF_FFFF;
	endfunction

	function automatic row_t req_row(input req_t r);
		row_t w;
		w = '{is_reg: 1'b0, reg_idx: '0, reg_val: '0, rq: r, typed: 1'b0, want: '0};
		return w;
	endfunction

	function automatic row_t typed_row(input req_t r, input res_t s);
		row_t w;
		w = req_row(r);
		w.typed = 1'b1;
		w.want = s;
		return w;
	endfunction

	function automatic row_t reg_row(input logic [1:0] idx, input logic [31:0] val);
		row_t w;
		w = req_row('0);
		w.is_reg = 1'b1;
		w.reg_idx = idx;
		w.reg_val = val;
		return w;
	endfunction

	initial begin
		row_t        plan[$];
		int          cap;
		int          n_next;
		int          phase_end;
		bit          pressed;
		logic [8:0]  cb;
		logic [31:0] slab_len;
		logic [2:0]  dims;

		sh_cell_bytes = 9'd1;
		sh_slab_len = 32'd1;
		sh_dims = 3'd1;
		walking = 1'b0;
		for (int i = 0; i < DIMS; i++) begin
			odo_coord[i] = '0;
			odo_last[i] = '0;
			dst_step[i] = '0;
			src_step[i] = '0;
			dst_base[i] = '0;
			src_base[i] = '0;
		end

		// One dimension with reset registers, then ignored requests around it.
		plan.insert(plan.size(), req_row(noise_req(FUNC_NEXT)));
		plan.insert(plan.size(), req_row(noise_req(FUNC_UNUSED)));
		plan.insert(plan.size(), req_row(load_req(2'd0, 32'd2, 32'd5, 32'd7)));
		plan.insert(plan.size(), req_row(start_req(32'd100, 32'd200)));
		plan.insert(plan.size(), typed_row(noise_req(FUNC_NEXT),
			{40'd200, 40'd100, 40'd1, 1'b0}));
		plan.insert(plan.size(), typed_row(noise_req(FUNC_NEXT),
			{40'd207, 40'd105, 40'd1, 1'b0}));
		plan.insert(plan.size(), typed_row(noise_req(FUNC_NEXT),
			{40'd214, 40'd110, 40'd1, 1'b1}));
		plan.insert(plan.size(), req_row(noise_req(FUNC_NEXT)));
		// Large registers and the largest strides; the byte arithmetic wraps at 40 bits.
		plan.insert(plan.size(), reg_row(CFG_CELL_BYTES, 32'd256));
		plan.insert(plan.size(), reg_row(CFG_SLAB_ELEMENTS, 32'hFFFF_FFFF));
		plan.insert(plan.size(), reg_row(CFG_DIMS_IN_USE, 32'd4));
		plan.insert(plan.size(),
			req_row(load_req(2'd0, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF)));
		plan.insert(plan.size(), req_row(load_req(2'd1, 32'd0, 32'd0, 32'd0)));
		plan.insert(plan.size(), req_row(load_req(2'd2, 32'd0, 32'd0, 32'd0)));
		plan.insert(plan.size(), req_row(load_req(2'd3, 32'd1, 32'd1, 32'd2)));
		plan.insert(plan.size(), req_row(start_req(32'hFFFF_FFFF, 32'hFFFF_FFFF)));
		plan.insert(plan.size(), typed_row(noise_req(FUNC_NEXT),
			{40'hFF_FFFF_FF00, 40'hFF_FFFF_FF00, 40'hFF_FFFF_FF00, 1'b0}));
		plan.insert(plan.size(), req_row(noise_req(FUNC_NEXT)));
		// The inner last value is lowered in the middle of a walk.
		plan.insert(plan.size(), req_row(load_req(2'd3, 32'd0, 32'd1, 32'd2)));
		plan.insert(plan.size(), req_row(noise_req(FUNC_NEXT)));
		plan.insert(plan.size(), req_row(noise_req(FUNC_NEXT)));
		// Zero cell size, zero slab length and zero dimensions.
		plan.insert(plan.size(), reg_row(CFG_CELL_BYTES, 32'd0));
		plan.insert(plan.size(), reg_row(CFG_SLAB_ELEMENTS, 32'd0));
		plan.insert(plan.size(), reg_row(CFG_DIMS_IN_USE, 32'd0));
		plan.insert(plan.size(), req_row(start_req($urandom, $urandom)));
		plan.insert(plan.size(), typed_row(noise_req(FUNC_NEXT),
			{40'd0, 40'd0, 40'd0, 1'b0}));

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				settle();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
				cfg_we = 1'b0;
			end else begin
				typed_pending = plan[i].typed;
				typed_want = plan[i].want;
				send(plan[i].rq);
				typed_pending = 1'b0;
			end
		end

		while (useful < TARGET) begin
			settle();
			case ($urandom_range(0, 5))
				0: cb = 9'd0;
				1: cb = 9'd1;
				2: cb = 9'd256;
				3: cb = 9'd511;
				default: cb = 9'($urandom_range(1, 256));
			endcase
			case ($urandom_range(0, 5))
				0: slab_len = 32'd0;
				1: slab_len = 32'd1;
				2: slab_len = 32'hFFFF_FFFF;
				3: slab_len = $urandom;
				default: slab_len = $urandom_range(1, 64);
			endcase
			dims = $urandom_range(0, 1) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
			write_reg(CFG_CELL_BYTES, {23'($urandom), cb});
			write_reg(CFG_SLAB_ELEMENTS, slab_len);
			write_reg(CFG_DIMS_IN_USE, {29'($urandom), dims});
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_UNUSED, $urandom);
			cfg_we = 1'b0;
			settings_used++;

			gappy = (useful < TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
			phase_end = useful + $urandom_range(120, 260);
			pressed = 1'b0;
			while (useful < phase_end && useful < TARGET) begin
				for (int d = 0; d < DIMS; d++)
					if ($urandom_range(0, 3) != 0)
						feed(load_req(2'(d), pick_last(), $urandom, $urandom));
				feed(start_req($urandom, $urandom));
				cap = $urandom_range(1, 64);
				n_next = 0;
				while (walking && n_next < cap) begin
					case ($urandom_range(0, 29))
						0: feed(load_req(2'($urandom), pick_last(), $urandom, $urandom));
						1: feed(noise_req(FUNC_UNUSED));
						2: feed(start_req($urandom, $urandom));
						default: begin
							feed(noise_req(FUNC_NEXT));
							n_next++;
						end
					endcase
				end
				repeat ($urandom_range(0, 2)) feed(noise_req(FUNC_NEXT));
				// Hold further requests until every slab so far has arrived.
				if (!pressed && $urandom_range(0, 1)) begin
					drain();
					pressed = 1'b1;
				end
			end
		end

		drain();
		repeat (20) @(negedge clk);
		$display("Run covered %0d requests over %0d register settings.",
			useful, settings_used + 3);
		$display("%0d slabs checked, %0d walks reached their last slab, %0d mismatches.",
			slabs_seen, walks_done, errors);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/ssag_pkg.sv
hdl/strided_slab_address_generator_unit.sv
test/strided_slab_address_generator_unit_test.sv
